@@ hw/rtl/three_channel_moving_average_macros.svh @@
// ---------------------------------------------------------------------------
// three_channel_moving_average_macros
// Assertion helpers for the three-channel moving average. They sample on clk
// and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef THREE_CHANNEL_MOVING_AVERAGE_MACROS_SVH
`define THREE_CHANNEL_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication
`define TCMA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcma: same-cycle check failed");

// next-cycle implication
`define TCMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcma: next-cycle check failed");

`endif

@@ hw/rtl/tcma_pkg.sv @@
// ---------------------------------------------------------------------------
// tcma_pkg
// Shared widths, register map and lane handshake types of the three-channel
// moving average.
// ---------------------------------------------------------------------------
package tcma_pkg;

    localparam int T_SAMPLE_W     = 15;
    localparam int H_SAMPLE_W     = 17;
    localparam int P_SAMPLE_W     = 17;
    localparam int FIELD_SUM_W    = T_SAMPLE_W + H_SAMPLE_W + P_SAMPLE_W;
    localparam int TDATA_W        = ((FIELD_SUM_W + 7) / 8) * 8;
    localparam int TUSER_W        = 3;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int WIN_W          = 6;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd20;

    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;
    localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LENGTH = '0;

    typedef struct packed {
        logic start;
        logic take;
        logic ack;
    } lane_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

endpackage

@@ hw/rtl/three_channel_moving_average.sv @@
// ---------------------------------------------------------------------------
// three_channel_moving_average
// Boxcar moving average of temperature, humidity and pressure with skipping
// of missing readings; one lane per channel and a merging output register.
//
// Usage:
//   s_axis carries one sample request: three readings in tdata, their present
//   flags in tuser. m_axis returns one result request per sample: the three
//   window means in tdata, their valid flags in tuser.
//   window_length sits at APB byte address 0; the user must write it only
//   while idle, and the block itself does not enforce this. A request passes
//   the sum update, the divider load, one restoring-divider step per quotient
//   bit of SUM_W, the widest lane sum (17 + log2(MAX_WINDOW) bits, 22 by
//   default), and the output register on its way to m_axis. A new request is
//   taken the cycle after the lanes are released, so the lanes never take a
//   new request before they are through with the last one.
//   Reset empties all channels and sets window_length to 20; the rings need
//   no clearing. A result that is not taken stays in the output register
//   while the lanes work on the next request; once that one is done too, the
//   lanes hold their finished means and s_axis_tready stays low.
// ---------------------------------------------------------------------------
`include "three_channel_moving_average_macros.svh"

module three_channel_moving_average
    import tcma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // temperature_sample, humidity_sample, pressure_sample, zero pad
    input  logic [TDATA_W-1:0]      s_axis_tdata,
    // temperature_present, humidity_present, pressure_present
    input  logic [TUSER_W-1:0]      s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // temperature_mean, humidity_mean, pressure_mean, zero pad
    output logic [TDATA_W-1:0]      m_axis_tdata,
    // temperature_mean_valid, humidity_mean_valid, pressure_mean_valid
    output logic [TUSER_W-1:0]      m_axis_tuser
);

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (WIN_W > FILL_W) ? WIN_W : FILL_W;

    logic [WIN_W-1:0]        window_reg;
    logic [CMP_W-1:0]        win_ext;
    logic [CMP_W-1:0]        win_cap;
    logic [FILL_W-1:0]       win_eff;
    logic                    accept;
    logic                    win_open;
    logic                    ack;
    lane_ctrl_t              t_ctrl;
    lane_ctrl_t              h_ctrl;
    lane_ctrl_t              p_ctrl;
    lane_stat_t              t_stat;
    lane_stat_t              h_stat;
    lane_stat_t              p_stat;
    logic [T_SAMPLE_W-1:0]   t_mean;
    logic [H_SAMPLE_W-1:0]   h_mean;
    logic [P_SAMPLE_W-1:0]   p_mean;
    logic                    t_valid;
    logic                    h_valid;
    logic                    p_valid;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH))
        begin
            window_reg <= pwdata[WIN_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[APB_ADDR_W-1:2])
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(window_reg);
            default:           prdata = '0;
        endcase
    end

    // a window above the ring depth acts as the ring depth
    assign win_ext  = CMP_W'(window_reg);
    assign win_cap  = (win_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : win_ext;
    assign win_eff  = win_cap[FILL_W-1:0];
    assign win_open = (win_eff != '0);

    assign s_axis_tready = t_stat.idle && h_stat.idle && p_stat.idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign t_ctrl = '{start: accept, take: win_open && s_axis_tuser[0], ack: ack};
    assign h_ctrl = '{start: accept, take: win_open && s_axis_tuser[1], ack: ack};
    assign p_ctrl = '{start: accept, take: win_open && s_axis_tuser[2], ack: ack};

    tcma_lane #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_W   (T_SAMPLE_W),
        .SIGNED     (1'b1)
    ) u_lane_t (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (t_ctrl),
        .sample     (s_axis_tdata[T_SAMPLE_W-1:0]),
        .win        (win_eff),
        .stat       (t_stat),
        .mean       (t_mean),
        .mean_valid (t_valid)
    );

    tcma_lane #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_W   (H_SAMPLE_W),
        .SIGNED     (1'b0)
    ) u_lane_h (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (h_ctrl),
        .sample     (s_axis_tdata[T_SAMPLE_W +: H_SAMPLE_W]),
        .win        (win_eff),
        .stat       (h_stat),
        .mean       (h_mean),
        .mean_valid (h_valid)
    );

    tcma_lane #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_W   (P_SAMPLE_W),
        .SIGNED     (1'b0)
    ) u_lane_p (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (p_ctrl),
        .sample     (s_axis_tdata[T_SAMPLE_W + H_SAMPLE_W +: P_SAMPLE_W]),
        .win        (win_eff),
        .stat       (p_stat),
        .mean       (p_mean),
        .mean_valid (p_valid)
    );

    tcma_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .t_stat        (t_stat),
        .h_stat        (h_stat),
        .p_stat        (p_stat),
        .t_mean        (t_mean),
        .t_valid       (t_valid),
        .h_mean        (h_mean),
        .h_valid       (h_valid),
        .p_mean        (p_mean),
        .p_valid       (p_valid),
        .ack           (ack),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // lanes are busy right after taking a request
    `TCMA_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready)

    // an empty temperature channel reports a zero mean
    `TCMA_ASSERT_IMPL(a_empty_mean_zero, m_axis_tvalid && !m_axis_tuser[0],
                      m_axis_tdata[T_SAMPLE_W-1:0] == '0)

    // a result never appears the cycle after a request is taken
    `TCMA_ASSERT_NEXT(a_no_instant_result, accept && !m_axis_tvalid, !m_axis_tvalid)

endmodule

@@ hw/rtl/tcma_lane.sv @@
// ---------------------------------------------------------------------------
// tcma_lane
// One channel: sample ring in a memory, running sum, fill count and write
// slot, followed by a bit-serial restoring divider for sum / fill.
// ---------------------------------------------------------------------------
module tcma_lane
    import tcma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int SAMPLE_W   = H_SAMPLE_W,
    parameter bit SIGNED     = 1'b0
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lane_ctrl_t                           ctrl,
    input  logic [SAMPLE_W-1:0]                  sample,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]      win,
    output lane_stat_t                           stat,
    output logic [SAMPLE_W-1:0]                  mean,
    output logic                                 mean_valid
);

    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    localparam int CNT_W  = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  take_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic [SUM_W-1:0]      dvd_reg;
    logic [SUM_W-1:0]      quo_reg;
    logic [FILL_W-1:0]     rem_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [SAMPLE_W-1:0]   ring_mem [MAX_WINDOW];

    logic [SUM_W-1:0]      sample_ext;
    logic [SUM_W-1:0]      old_ext;
    logic                  full;
    logic [SUM_W-1:0]      sum_next;
    logic [IDX_W:0]        slot_inc;
    logic [IDX_W-1:0]      slot_next;
    logic                  sum_neg;
    logic [SUM_W-1:0]      sum_mag;
    logic [FILL_W:0]       trial;
    logic                  fit;
    logic [FILL_W:0]       trial_diff;
    logic [FILL_W-1:0]     rem_next;
    logic [SAMPLE_W-1:0]   quo_low;
    logic                  wr_en;

    function automatic logic [SUM_W-1:0] widen(input logic [SAMPLE_W-1:0] v);
        logic fill_bit;
        fill_bit = SIGNED & v[SAMPLE_W-1];
        widen = {{IDX_W{fill_bit}}, v};
    endfunction

    always_comb
    begin
        sample_ext = widen(sample_reg);
        old_ext    = widen(rd_data_reg);
        full       = (fill_reg >= win);
        sum_next   = sum_reg - (full ? old_ext : '0) + sample_ext;
        slot_inc   = {1'b0, slot_reg} + 1'b1;
        slot_next  = (slot_inc >= (IDX_W+1)'(win)) ? '0 : slot_inc[IDX_W-1:0];
        sum_neg    = SIGNED & sum_reg[SUM_W-1];
        sum_mag    = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
        trial      = {rem_reg, dvd_reg[SUM_W-1]};
        fit        = (trial >= {1'b0, fill_reg});
        trial_diff = trial - {1'b0, fill_reg};
        rem_next   = fit ? trial_diff[FILL_W-1:0] : trial[FILL_W-1:0];
        quo_low    = quo_reg[SAMPLE_W-1:0];
    end

    assign wr_en = (state_reg == ST_UPDATE) && take_reg;

    // ring read is registered; the address is the write slot, which only
    // moves in the update step
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sample_reg <= '0;
            take_reg   <= 1'b0;
            sum_reg    <= '0;
            fill_reg   <= '0;
            slot_reg   <= '0;
            dvd_reg    <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        sample_reg <= sample;
                        take_reg   <= ctrl.take;
                        state_reg  <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (take_reg)
                    begin
                        sum_reg  <= sum_next;
                        slot_reg <= slot_next;
                        if (!full)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    neg_reg   <= sum_neg;
                    dvd_reg   <= sum_mag;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= CNT_W'(SUM_W);
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    // one quotient bit per cycle, msb first
                    dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[SUM_W-2:0], fit};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (ctrl.ack)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.idle  = (state_reg == ST_IDLE);
    assign stat.done  = (state_reg == ST_DONE);
    assign mean_valid = (fill_reg != '0);
    assign mean       = !mean_valid ? '0 : (neg_reg ? (~quo_low + 1'b1) : quo_low);

endmodule

@@ hw/rtl/tcma_merge.sv @@
// ---------------------------------------------------------------------------
// tcma_merge
// Waits for all three lanes, packs their means into the output register and
// releases the lanes.
// ---------------------------------------------------------------------------
module tcma_merge
    import tcma_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_stat_t              t_stat,
    input  lane_stat_t              h_stat,
    input  lane_stat_t              p_stat,
    input  logic [T_SAMPLE_W-1:0]   t_mean,
    input  logic                    t_valid,
    input  logic [H_SAMPLE_W-1:0]   h_mean,
    input  logic                    h_valid,
    input  logic [P_SAMPLE_W-1:0]   p_mean,
    input  logic                    p_valid,
    output logic                    ack,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic [TUSER_W-1:0]      m_axis_tuser
);

    logic                 tvalid_reg;
    logic [TDATA_W-1:0]   tdata_reg;
    logic [TUSER_W-1:0]   tuser_reg;
    logic                 load;

    assign load = t_stat.done && h_stat.done && p_stat.done
                  && (!tvalid_reg || m_axis_tready);
    assign ack  = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else if (load)
        begin
            tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= TDATA_W'({p_mean, h_mean, t_mean});
            tuser_reg <= {p_valid, h_valid, t_valid};
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule
